### design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// check while out of reset
`define GFQ_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// check on every edge, reset included
`define GFQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GFQ_ASSERT(lbl, clk, rst, prop, msg)
`define GFQ_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

### design/gfq_pkg.sv
// ----------------------------------------------------------------------------
// gfq_pkg
// Shared constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package gfq_pkg;

   localparam int MEMBERS_DEF  = 1024;
   localparam int GROUPS_DEF   = 256;
   localparam int CAPACITY_DEF = 256;

   localparam int ACTION_W = 2;
   localparam int MEMBER_W = 10;
   localparam int GROUP_W  = 8;
   localparam int STATUS_W = 2;

   typedef enum logic [ACTION_W-1:0] {
      ACT_CLEAR   = 2'd0,
      ACT_ASSIGN  = 2'd1,
      ACT_ENQUEUE = 2'd2,
      ACT_DEQUEUE = 2'd3
   } action_type;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic                load;
      logic                sweep_start;
      logic                sweep_step;
      logic                assign_wr;
      logic                enq_b;
      logic                enq_c;
      logic                enq_d;
      logic                enq_e;
      logic                deq_b;
      logic                deq_c;
      logic                res_load;
      logic                res_member;
      logic [STATUS_W-1:0] res_status;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
      logic sweep_last;
   } stat_type;

endpackage

### design/grouped_fifo_queue.sv
// Grouped FIFO queue. One word in, one result word out, one operation at a
// time. An operation steps through its states (S_ASSIGN, S_ENQ_A to S_ENQ_E,
// S_DEQ_A to S_DEQ_C) to S_FINISH; a refused enqueue (full) or dequeue (empty)
// goes there at once. The next word is taken in the cycle after the result is
// registered. The steps follow the chain of registered RAM reads (group table,
// free stack, group tail, slot link) that each step waits on. After reset and
// after a clear-all word, a sweep of max(MEMBERS, GROUPS, CAPACITY) addresses
// (1024 by default) clears the group table, the waiting flags and reloads the
// free stack; no word is taken during it, and a clear's result follows it.
// MEMBERS, GROUPS and CAPACITY must be powers of two.
// ----------------------------------------------------------------------------
// grouped_fifo_queue
// Top level: sequencer plus linked-list datapath, with assertions.
// ----------------------------------------------------------------------------
module grouped_fifo_queue #(
   parameter int MEMBERS  = gfq_pkg::MEMBERS_DEF,
   parameter int GROUPS   = gfq_pkg::GROUPS_DEF,
   parameter int CAPACITY = gfq_pkg::CAPACITY_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [gfq_pkg::ACTION_W-1:0] req_action,
   input  logic [gfq_pkg::MEMBER_W-1:0] req_member,
   input  logic [gfq_pkg::GROUP_W-1:0]  req_group,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [gfq_pkg::MEMBER_W-1:0] rsp_out_member,
   output logic [gfq_pkg::STATUS_W-1:0] rsp_status
);
   import gfq_pkg::*;
`include "assert_macros.svh"

   cmd_type  cmd;
   stat_type stat;

   gfq_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .req_action,
      .rsp_valid, .rsp_ready, .cmd, .stat);

   gfq_dp #(.MEMBERS(MEMBERS), .GROUPS(GROUPS), .CAPACITY(CAPACITY)) u_dp (
      .clock, .reset, .cmd, .stat, .req_member, .req_group,
      .rsp_out_member, .rsp_status);

   `GFQ_ASSERT_ALWAYS(a_no_accept_in_sweep, clock,
      cmd.sweep_step |-> !req_ready, "word taken during sweep")
   `GFQ_ASSERT(a_one_at_a_time, clock, reset,
      (req_valid && req_ready) |=> !req_ready, "second word taken while busy")
   `GFQ_ASSERT(a_no_overwrite, clock, reset,
      cmd.res_load |-> (!rsp_valid || rsp_ready), "pending result overwritten")
   `GFQ_ASSERT(a_full_not_empty, clock, reset,
      !(stat.full && stat.empty), "occupancy both full and empty")

endmodule

### design/gfq_ram.sv
// ----------------------------------------------------------------------------
// gfq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gfq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### design/gfq_ctrl.sv
// ----------------------------------------------------------------------------
// gfq_ctrl
// Sequencer: steps each operation through the datapath and owns the
// handshakes and the clearing sweep.
// ----------------------------------------------------------------------------
module gfq_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [gfq_pkg::ACTION_W-1:0] req_action,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output gfq_pkg::cmd_type            cmd,
   input  gfq_pkg::stat_type           stat
);
   import gfq_pkg::*;

   typedef enum logic [3:0] {
      S_SWEEP, S_IDLE, S_ASSIGN,
      S_ENQ_A, S_ENQ_B, S_ENQ_C, S_ENQ_D, S_ENQ_E,
      S_DEQ_A, S_DEQ_B, S_DEQ_C, S_FINISH
   } state_type;

   state_type           state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                clr_pend_ff, clr_pend_in;
   logic                fin_deq_ff, fin_deq_in;
   logic [STATUS_W-1:0] fin_status_ff, fin_status_in;
   logic                accept;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in      = state_ff;
      clr_pend_in   = clr_pend_ff;
      fin_deq_in    = fin_deq_ff;
      fin_status_in = fin_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      cmd           = '0;
      cmd.res_member = fin_deq_ff;
      cmd.res_status = fin_status_ff;
      case (state_ff)
         S_SWEEP: begin
            cmd.sweep_step = 1'b1;
            if (stat.sweep_last) begin
               state_in    = clr_pend_ff ? S_FINISH : S_IDLE;
               clr_pend_in = 1'b0;
            end
         end
         S_IDLE: begin
            if (accept) begin
               cmd.load      = 1'b1;
               fin_deq_in    = 1'b0;
               fin_status_in = ST_OK;
               case (req_action)
                  ACT_CLEAR: begin
                     cmd.sweep_start = 1'b1;
                     clr_pend_in     = 1'b1;
                     state_in        = S_SWEEP;
                  end
                  ACT_ASSIGN: begin
                     state_in = S_ASSIGN;
                  end
                  ACT_ENQUEUE: begin
                     if (stat.full) begin
                        fin_status_in = ST_FULL;
                        state_in      = S_FINISH;
                     end else begin
                        state_in = S_ENQ_A;
                     end
                  end
                  default: begin
                     if (stat.empty) begin
                        fin_status_in = ST_EMPTY;
                        state_in      = S_FINISH;
                     end else begin
                        fin_deq_in = 1'b1;
                        state_in   = S_DEQ_A;
                     end
                  end
               endcase
            end
         end
         S_ASSIGN: begin
            cmd.assign_wr = 1'b1;
            state_in      = S_FINISH;
         end
         S_ENQ_A: state_in = S_ENQ_B;
         S_ENQ_B: begin
            cmd.enq_b = 1'b1;
            state_in  = S_ENQ_C;
         end
         S_ENQ_C: begin
            cmd.enq_c = 1'b1;
            state_in  = S_ENQ_D;
         end
         S_ENQ_D: begin
            cmd.enq_d = 1'b1;
            state_in  = S_ENQ_E;
         end
         S_ENQ_E: begin
            cmd.enq_e = 1'b1;
            state_in  = S_FINISH;
         end
         S_DEQ_A: state_in = S_DEQ_B;
         S_DEQ_B: begin
            cmd.deq_b = 1'b1;
            state_in  = S_DEQ_C;
         end
         S_DEQ_C: begin
            cmd.deq_c = 1'b1;
            state_in  = S_FINISH;
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.res_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_SWEEP;
         rsp_valid_ff  <= 1'b0;
         clr_pend_ff   <= 1'b0;
         fin_deq_ff    <= 1'b0;
         fin_status_ff <= ST_OK;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         clr_pend_ff   <= clr_pend_in;
         fin_deq_ff    <= fin_deq_in;
         fin_status_ff <= fin_status_in;
      end
   end

endmodule

### design/gfq_dp.sv
// ----------------------------------------------------------------------------
// gfq_dp
// Datapath: group table, slot lists, free stack, per-group tails and the
// queue pointers, driven step by step by the controller.
// ----------------------------------------------------------------------------
module gfq_dp #(
   parameter int MEMBERS  = gfq_pkg::MEMBERS_DEF,
   parameter int GROUPS   = gfq_pkg::GROUPS_DEF,
   parameter int CAPACITY = gfq_pkg::CAPACITY_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  gfq_pkg::cmd_type             cmd,
   output gfq_pkg::stat_type            stat,
   input  logic [gfq_pkg::MEMBER_W-1:0] req_member,
   input  logic [gfq_pkg::GROUP_W-1:0]  req_group,
   output logic [gfq_pkg::MEMBER_W-1:0] rsp_out_member,
   output logic [gfq_pkg::STATUS_W-1:0] rsp_status
);
   import gfq_pkg::*;

   localparam int MW = $clog2(MEMBERS);
   localparam int GW = $clog2(GROUPS);
   localparam int SW = $clog2(CAPACITY);
   localparam int MG = (MEMBERS > GROUPS) ? MEMBERS : GROUPS;
   localparam int SWEEP_DEPTH = (MG > CAPACITY) ? MG : CAPACITY;
   localparam int DW = $clog2(SWEEP_DEPTH);

   logic [MEMBER_W-1:0] member_ff, member_in;
   logic [GW-1:0]       grp_ff, grp_in;
   logic [GW-1:0]       g_ff, g_in;
   logic [SW-1:0]       s_ff, s_in;
   logic [SW-1:0]       p_ff, p_in;
   logic                join_ff, join_in;
   logic                link_en_ff, link_en_in;
   logic [SW-1:0]       link_addr_ff, link_addr_in;
   logic [MEMBER_W-1:0] dmem_ff, dmem_in;
   logic [SW-1:0]       nxt_ff, nxt_in;
   logic [SW-1:0]       head_ff, head_in;
   logic [SW-1:0]       tail_ff, tail_in;
   logic [SW:0]         occ_ff, occ_in;
   logic [DW-1:0]       cnt_ff, cnt_in;
   logic [MEMBER_W-1:0] rsp_member_ff, rsp_member_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   logic [GW-1:0]       gtab_q, sgrp_q;
   logic [SW-1:0]       fs_q, gtail_q, snext_q;
   logic                wait_q;
   logic [MEMBER_W-1:0] smem_q;
   logic [SW:0]         occ_dec;
   logic                sw_m, sw_g, sw_c, wait_clr;

   logic              gtab_we;
   logic [MW-1:0]     gtab_wa;
   logic [GW-1:0]     gtab_wd;
   logic              fs_we;
   logic [SW-1:0]     fs_wa, fs_wd;
   logic              gwait_we, gwait_wd;
   logic [GW-1:0]     gwait_wa, grp_ra;
   logic              snext_we;
   logic [SW-1:0]     snext_wa, snext_wd, snext_ra;
   logic              gtail_we, slot_we;

   assign occ_dec  = occ_ff - 1'b1;
   assign sw_m     = cmd.sweep_step && ({1'b0, cnt_ff} < (DW+1)'(MEMBERS));
   assign sw_g     = cmd.sweep_step && ({1'b0, cnt_ff} < (DW+1)'(GROUPS));
   assign sw_c     = cmd.sweep_step && ({1'b0, cnt_ff} < (DW+1)'(CAPACITY));
   assign wait_clr = (g_ff != '0) && wait_q && (gtail_q == head_ff);

   assign stat.full       = (occ_ff == (SW+1)'(CAPACITY));
   assign stat.empty      = (occ_ff == '0);
   assign stat.sweep_last = (cnt_ff == DW'(SWEEP_DEPTH - 1));

   // write ports and read addresses
   always_comb begin
      gtab_we  = sw_m || cmd.assign_wr;
      gtab_wa  = cmd.sweep_step ? cnt_ff[MW-1:0] : MW'(member_ff);
      gtab_wd  = cmd.sweep_step ? '0 : grp_ff;
      fs_we    = sw_c || cmd.deq_c;
      fs_wa    = cmd.sweep_step ? cnt_ff[SW-1:0] : occ_dec[SW-1:0];
      fs_wd    = cmd.sweep_step ? cnt_ff[SW-1:0] : head_ff;
      gwait_we = sw_g || (cmd.enq_d && g_ff != '0) || (cmd.deq_c && wait_clr);
      gwait_wa = cmd.sweep_step ? cnt_ff[GW-1:0] : g_ff;
      gwait_wd = cmd.enq_d;
      gtail_we = cmd.enq_d && (g_ff != '0);
      slot_we  = cmd.enq_d;
      snext_we = cmd.enq_d || (cmd.enq_e && link_en_ff);
      snext_wa = cmd.enq_d ? s_ff : link_addr_ff;
      snext_wd = cmd.enq_d ? (join_ff ? snext_q : '0) : s_ff;
      snext_ra = cmd.enq_c ? gtail_q : head_ff;
      grp_ra   = cmd.enq_b ? gtab_q : sgrp_q;
   end

   gfq_ram #(.WIDTH(GW), .DEPTH(MEMBERS)) u_gtab (
      .clock, .wr_en(gtab_we), .wr_addr(gtab_wa), .wr_data(gtab_wd),
      .rd_addr(MW'(member_ff)), .rd_data(gtab_q));

   gfq_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_fstk (
      .clock, .wr_en(fs_we), .wr_addr(fs_wa), .wr_data(fs_wd),
      .rd_addr(occ_ff[SW-1:0]), .rd_data(fs_q));

   gfq_ram #(.WIDTH(1), .DEPTH(GROUPS)) u_gwait (
      .clock, .wr_en(gwait_we), .wr_addr(gwait_wa), .wr_data(gwait_wd),
      .rd_addr(grp_ra), .rd_data(wait_q));

   gfq_ram #(.WIDTH(SW), .DEPTH(GROUPS)) u_gtail (
      .clock, .wr_en(gtail_we), .wr_addr(g_ff), .wr_data(s_ff),
      .rd_addr(grp_ra), .rd_data(gtail_q));

   gfq_ram #(.WIDTH(MEMBER_W), .DEPTH(CAPACITY)) u_smem (
      .clock, .wr_en(slot_we), .wr_addr(s_ff), .wr_data(member_ff),
      .rd_addr(head_ff), .rd_data(smem_q));

   gfq_ram #(.WIDTH(GW), .DEPTH(CAPACITY)) u_sgrp (
      .clock, .wr_en(slot_we), .wr_addr(s_ff), .wr_data(g_ff),
      .rd_addr(head_ff), .rd_data(sgrp_q));

   gfq_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_snext (
      .clock, .wr_en(snext_we), .wr_addr(snext_wa), .wr_data(snext_wd),
      .rd_addr(snext_ra), .rd_data(snext_q));

   always_comb begin
      member_in     = cmd.load ? req_member : member_ff;
      grp_in        = cmd.load ? GW'(req_group) : grp_ff;
      g_in          = g_ff;
      s_in          = s_ff;
      p_in          = p_ff;
      join_in       = join_ff;
      link_en_in    = link_en_ff;
      link_addr_in  = link_addr_ff;
      dmem_in       = dmem_ff;
      nxt_in        = nxt_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      occ_in        = occ_ff;
      cnt_in        = cnt_ff;
      rsp_member_in = rsp_member_ff;
      rsp_status_in = rsp_status_ff;
      if (cmd.sweep_start) begin
         head_in = '0;
         tail_in = '0;
         occ_in  = '0;
         cnt_in  = '0;
      end
      if (cmd.sweep_step) begin
         cnt_in = cnt_ff + 1'b1;
      end
      if (cmd.enq_b) begin
         g_in = gtab_q;
         s_in = fs_q;
      end
      if (cmd.enq_c) begin
         join_in = (g_ff != '0) && wait_q;
         p_in    = gtail_q;
      end
      if (cmd.enq_d) begin
         link_en_in   = join_ff || !stat.empty;
         link_addr_in = join_ff ? p_ff : tail_ff;
         if (join_ff) begin
            if (p_ff == tail_ff) begin
               tail_in = s_ff;
            end
         end else begin
            if (stat.empty) begin
               head_in = s_ff;
            end
            tail_in = s_ff;
         end
         occ_in = occ_ff + 1'b1;
      end
      if (cmd.deq_b) begin
         g_in    = sgrp_q;
         dmem_in = smem_q;
         nxt_in  = snext_q;
      end
      if (cmd.deq_c) begin
         head_in = nxt_ff;
         occ_in  = occ_dec;
      end
      if (cmd.res_load) begin
         rsp_member_in = cmd.res_member ? dmem_ff : '0;
         rsp_status_in = cmd.res_status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         occ_ff  <= '0;
         cnt_ff  <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         occ_ff  <= occ_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      member_ff     <= member_in;
      grp_ff        <= grp_in;
      g_ff          <= g_in;
      s_ff          <= s_in;
      p_ff          <= p_in;
      join_ff       <= join_in;
      link_en_ff    <= link_en_in;
      link_addr_ff  <= link_addr_in;
      dmem_ff       <= dmem_in;
      nxt_ff        <= nxt_in;
      rsp_member_ff <= rsp_member_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_out_member = rsp_member_ff;
   assign rsp_status     = rsp_status_ff;

endmodule
